>>> hw/rtl/dtkc_pkg.sv
// Shared types, register offsets and constants of the DMA task kick and completion register block.
package dtkc_pkg;

  // Bus word fields.
  localparam int unsigned ADDR_W  = 20;
  localparam int unsigned WA_W    = ADDR_W - 2;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned CADDR_W = 41;
  localparam int unsigned CLEN_W  = 26;
  localparam int unsigned CHIP_W  = 8;

  // Packed stream words.
  localparam int unsigned IN_TDATA_W  = 56;
  localparam int unsigned OUT_TDATA_W = 152;

  // Default sizes.
  localparam int unsigned RING_SLOTS_DEF  = 32;
  localparam int unsigned STORE_WORDS_DEF = 256;

  // Copy length limit in bytes.
  localparam logic [38:0] MAX_COPY_BYTES = 39'd33554432;

  // Register byte offsets.
  localparam logic [ADDR_W-1:0] OFF_DEPTH   = 20'h120;
  localparam logic [ADDR_W-1:0] OFF_POP     = 20'h128;
  localparam logic [ADDR_W-1:0] OFF_CRD_LO  = 20'h180;
  localparam logic [ADDR_W-1:0] OFF_CRD_HI  = 20'h190;
  localparam logic [ADDR_W-1:0] OFF_TASK_ID = 20'h200;
  localparam logic [ADDR_W-1:0] OFF_SRC     = 20'h204;
  localparam logic [ADDR_W-1:0] OFF_DST     = 20'h208;
  localparam logic [ADDR_W-1:0] OFF_BLOCKS  = 20'h20C;
  localparam logic [ADDR_W-1:0] OFF_TYPE    = 20'h218;
  localparam logic [ADDR_W-1:0] OFF_KICK    = 20'h21C;

  // The same offsets as word addresses.
  localparam logic [WA_W-1:0] WA_DEPTH   = OFF_DEPTH[ADDR_W-1:2];
  localparam logic [WA_W-1:0] WA_POP     = OFF_POP[ADDR_W-1:2];
  localparam logic [WA_W-1:0] WA_CRD_LO  = OFF_CRD_LO[ADDR_W-1:2];
  localparam logic [WA_W-1:0] WA_CRD_HI  = OFF_CRD_HI[ADDR_W-1:2];
  localparam logic [WA_W-1:0] WA_TASK_ID = OFF_TASK_ID[ADDR_W-1:2];
  localparam logic [WA_W-1:0] WA_SRC     = OFF_SRC[ADDR_W-1:2];
  localparam logic [WA_W-1:0] WA_DST     = OFF_DST[ADDR_W-1:2];
  localparam logic [WA_W-1:0] WA_BLOCKS  = OFF_BLOCKS[ADDR_W-1:2];
  localparam logic [WA_W-1:0] WA_TYPE    = OFF_TYPE[ADDR_W-1:2];
  localparam logic [WA_W-1:0] WA_KICK    = OFF_KICK[ADDR_W-1:2];

  // Free credit reported by the credit window.
  localparam logic [DATA_W-1:0] CREDIT_FREE = 32'd32;

  // Task type field and its one-to-one copy code.
  localparam logic [3:0] TYPE_COPY = 4'h0;

  // Identity seeds at word addresses zero to five; word two carries the die index.
  localparam int unsigned        IDENT_WORDS = 6;
  localparam logic [WA_W-1:0]    WA_IDENT_CHIP = 18'd2;
  localparam logic [DATA_W-1:0]  IDENT_SEED [IDENT_WORDS] = '{
    32'h2026_0101, 32'h0101_0100, 32'h0000_0000,
    32'h0000_0800, 32'h0020_2020, 32'h0820_2020
  };

  typedef enum logic [2:0] {
    KS_NONE   = 3'd0,
    KS_OK     = 3'd1,
    KS_ZERO   = 3'd2,
    KS_UNIMPL = 3'd3,
    KS_FULL   = 3'd4
  } kick_status_e;

  // Task words as last written, zero when never written.
  typedef struct packed {
    logic [DATA_W-1:0] id;
    logic [DATA_W-1:0] src;
    logic [DATA_W-1:0] dst;
    logic [DATA_W-1:0] blocks;
    logic [DATA_W-1:0] ty;
  } task_t;

  // Result of a kick.
  typedef struct packed {
    logic               push;
    logic               pulse;
    logic               copy_valid;
    logic [CADDR_W-1:0] copy_src;
    logic [CADDR_W-1:0] copy_dst;
    logic [CLEN_W-1:0]  copy_bytes;
    kick_status_e       status;
  } kick_t;

  // Default read value of a register that holds no stored word.
  function automatic logic [DATA_W-1:0] default_word(input logic [WA_W-1:0] wa,
                                                     input logic [CHIP_W-1:0] chip);
    logic [DATA_W-1:0] v;
    v = '0;
    if (wa == WA_IDENT_CHIP) begin
      v = DATA_W'(chip);
    end else if (wa < WA_W'(IDENT_WORDS)) begin
      v = IDENT_SEED[wa[2:0]];
    end
    return v;
  endfunction

endpackage

>>> hw/rtl/dtkc_store.sv
// Register word store with written flags and shadow copies of the task words.
module dtkc_store #(
  parameter int unsigned STORE_WORDS = dtkc_pkg::STORE_WORDS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  logic                          wr_i,
  input  logic [dtkc_pkg::WA_W-1:0]     wa_i,
  input  logic [dtkc_pkg::DATA_W-1:0]   wdata_i,
  output logic [dtkc_pkg::DATA_W-1:0]   rdata_o,
  output logic                          written_o,
  output dtkc_pkg::task_t               task_o
);

  localparam int unsigned IDX_W = $clog2(STORE_WORDS);

  logic [dtkc_pkg::DATA_W-1:0] mem_q [STORE_WORDS];
  logic [STORE_WORDS-1:0]      written_q;
  logic                        written_out_q;
  logic [dtkc_pkg::DATA_W-1:0] rdata_q;
  dtkc_pkg::task_t             task_q;
  logic                        in_range;
  logic                        we;
  logic [IDX_W-1:0]            idx;

  assign in_range = (wa_i < dtkc_pkg::WA_W'(STORE_WORDS));
  assign idx      = wa_i[IDX_W-1:0];
  assign we       = acc_i && wr_i && in_range;

  // Word memory with a registered read at the access address.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[idx] <= wdata_i;
    end
    if (acc_i) begin
      rdata_q <= mem_q[idx];
    end
  end

  // Written flags, cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q     <= '0;
      written_out_q <= 1'b0;
    end else if (acc_i) begin
      written_out_q <= in_range && written_q[idx];
      if (we) begin
        written_q[idx] <= 1'b1;
      end
    end
  end

  // Task words kept beside the memory so a kick sees them all at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      task_q <= '0;
    end else if (acc_i && wr_i) begin
      case (wa_i)
        dtkc_pkg::WA_TASK_ID: task_q.id     <= wdata_i;
        dtkc_pkg::WA_SRC:     task_q.src    <= wdata_i;
        dtkc_pkg::WA_DST:     task_q.dst    <= wdata_i;
        dtkc_pkg::WA_BLOCKS:  task_q.blocks <= wdata_i;
        dtkc_pkg::WA_TYPE:    task_q.ty     <= wdata_i;
        default: ;
      endcase
    end
  end

  assign rdata_o   = rdata_q;
  assign written_o = written_out_q;
  assign task_o    = task_q;

endmodule

>>> hw/rtl/dtkc_ring.sv
// Completion ring of task ids with head and tail pointers and a registered pop read.
module dtkc_ring #(
  parameter int unsigned RING_SLOTS = dtkc_pkg::RING_SLOTS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          acc_i,
  input  logic                          push_i,
  input  logic [dtkc_pkg::DATA_W-1:0]   push_id_i,
  input  logic                          pop_i,
  output logic                          full_o,
  output logic                          nonempty_o,
  output logic [7:0]                    depth_o,
  output logic [dtkc_pkg::DATA_W-1:0]   rdata_o
);

  localparam int unsigned PTR_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;

  logic [dtkc_pkg::DATA_W-1:0] mem_q [RING_SLOTS];
  logic [dtkc_pkg::DATA_W-1:0] rdata_q;
  logic [PTR_W-1:0]            head_q, head_d;
  logic [PTR_W-1:0]            tail_q, tail_d;
  logic [PTR_W-1:0]            tail_nx;
  logic [PTR_W-1:0]            head_nx;
  logic [PTR_W:0]              diff;

  // Pointer successors wrap at the last slot.
  assign tail_nx = (tail_q == PTR_W'(RING_SLOTS - 1)) ? '0 : tail_q + PTR_W'(1);
  assign head_nx = (head_q == PTR_W'(RING_SLOTS - 1)) ? '0 : head_q + PTR_W'(1);

  assign full_o     = (tail_nx == head_q);
  assign nonempty_o = (head_q != tail_q);

  // Occupancy from the pointer distance.
  always_comb begin
    diff = {1'b0, tail_q} - {1'b0, head_q};
    if (tail_q < head_q) begin
      diff = diff + (PTR_W + 1)'(RING_SLOTS);
    end
  end
  assign depth_o = 8'(diff[PTR_W-1:0]);

  // Pointer updates.
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (pop_i && nonempty_o) begin
      head_d = head_nx;
    end
    if (push_i) begin
      tail_d = tail_nx;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  // Slot memory, written at the tail and read at the head.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_q] <= push_id_i;
    end
    if (acc_i) begin
      rdata_q <= mem_q[head_q];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/dtkc_kick.sv
// Kick decode: copy command fields, status, ring push and done pulse.
module dtkc_kick (
  input  logic                        kick_i,
  input  logic                        irq_off_i,
  input  logic                        ring_full_i,
  input  dtkc_pkg::task_t             task_i,
  output dtkc_pkg::kick_t             kick_o
);

  logic [38:0] size;
  logic [38:0] size_clamp;

  assign size       = {task_i.blocks, 7'b0};
  assign size_clamp = (size > dtkc_pkg::MAX_COPY_BYTES) ? dtkc_pkg::MAX_COPY_BYTES : size;

  // Task type decode and ring admission.
  always_comb begin
    kick_o = '0;
    kick_o.status = dtkc_pkg::KS_NONE;
    if (kick_i) begin
      if (task_i.ty[3:0] == dtkc_pkg::TYPE_COPY) begin
        if (task_i.blocks == '0) begin
          kick_o.status = dtkc_pkg::KS_ZERO;
        end else begin
          kick_o.copy_valid = 1'b1;
          kick_o.copy_src   = {task_i.ty[21:20], task_i.src, 7'b0};
          kick_o.copy_dst   = {task_i.ty[23:22], task_i.dst, 7'b0};
          kick_o.copy_bytes = size_clamp[dtkc_pkg::CLEN_W-1:0];
          kick_o.status     = dtkc_pkg::KS_OK;
        end
      end else begin
        kick_o.status = dtkc_pkg::KS_UNIMPL;
      end
      if (ring_full_i) begin
        kick_o.status = dtkc_pkg::KS_FULL;
      end else begin
        kick_o.push  = 1'b1;
        kick_o.pulse = !irq_off_i;
      end
    end
  end

endmodule

>>> hw/rtl/dma_task_kick_completion_regs.sv
// Top level: register access stream in, one result word out per access.
// An accepted word moves through the input stage register, then the output register.
// Throughput: one access per cycle unless m_axis_tready stalls; each stage holds one word.
// All store, ring and pointer updates happen at the accepting edge, so each access sees the last.
// Reset clears the written flags, ring pointers, task words and the chiplet number at once.
module dma_task_kick_completion_regs #(
  parameter int unsigned RING_SLOTS  = dtkc_pkg::RING_SLOTS_DEF,
  parameter int unsigned STORE_WORDS = dtkc_pkg::STORE_WORDS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dtkc_pkg::CHIP_W-1:0]         cfg_wdata_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // action [0], addr [20:1], write_data [52:21], zero fill above
  input  logic [dtkc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // read_data [31:0], done_pulse [32], copy_valid [33], copy_src [74:34],
  // copy_dst [115:75], copy_bytes [141:116], kick_status [144:142], zero fill above
  output logic [dtkc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  typedef enum logic [1:0] {
    RS_ZERO,
    RS_IMM,
    RS_POP,
    RS_STORE
  } rd_sel_e;

  typedef struct packed {
    rd_sel_e                     sel;
    logic [dtkc_pkg::DATA_W-1:0] imm;
    logic                        pop_hit;
    dtkc_pkg::kick_t             kick;
  } stage_t;

  logic [dtkc_pkg::CHIP_W-1:0]  chip_q;
  logic                         a_vq;
  logic                         m_vq;
  stage_t                       a_q, a_d;
  logic [dtkc_pkg::OUT_TDATA_W-1:0] m_data_q;
  logic                         acc;
  logic                         m_free;
  logic                         a_adv;

  logic                         in_action;
  logic [dtkc_pkg::ADDR_W-1:0]  in_addr;
  logic [dtkc_pkg::DATA_W-1:0]  in_wdata;
  logic [dtkc_pkg::WA_W-1:0]    wa;
  logic                         is_kick;
  logic                         is_pop;

  logic [dtkc_pkg::DATA_W-1:0]  st_rdata;
  logic                         st_written;
  dtkc_pkg::task_t              task_w;
  logic                         ring_full;
  logic                         ring_nonempty;
  logic [7:0]                   ring_depth;
  logic [dtkc_pkg::DATA_W-1:0]  ring_rdata;
  dtkc_pkg::kick_t              kick;
  logic [dtkc_pkg::DATA_W-1:0]  rd_out;

  // Input word fields.
  assign in_action = s_axis_tdata[0];
  assign in_addr   = s_axis_tdata[20:1];
  assign in_wdata  = s_axis_tdata[52:21];
  assign wa        = in_addr[dtkc_pkg::ADDR_W-1:2];

  // Handshake between input stage and output register.
  assign m_free        = !m_vq || m_axis_tready;
  assign a_adv         = a_vq && m_free;
  assign s_axis_tready = !a_vq || m_free;
  assign acc           = s_axis_tvalid && s_axis_tready;

  assign is_kick = in_action && (wa == dtkc_pkg::WA_KICK);
  assign is_pop  = acc && !in_action && (wa == dtkc_pkg::WA_POP);

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chip_q <= '0;
    end else if (cfg_we_i) begin
      chip_q <= cfg_wdata_i;
    end
  end

  dtkc_store #(
    .STORE_WORDS (STORE_WORDS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .wr_i      (in_action),
    .wa_i      (wa),
    .wdata_i   (in_wdata),
    .rdata_o   (st_rdata),
    .written_o (st_written),
    .task_o    (task_w)
  );

  dtkc_kick u_kick (
    .kick_i      (is_kick),
    .irq_off_i   (in_wdata[0]),
    .ring_full_i (ring_full),
    .task_i      (task_w),
    .kick_o      (kick)
  );

  dtkc_ring #(
    .RING_SLOTS (RING_SLOTS)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (acc),
    .push_i     (acc && kick.push),
    .push_id_i  (task_w.id),
    .pop_i      (is_pop),
    .full_o     (ring_full),
    .nonempty_o (ring_nonempty),
    .depth_o    (ring_depth),
    .rdata_o    (ring_rdata)
  );

  // Read decode, first match wins.
  always_comb begin
    a_d         = '0;
    a_d.sel     = RS_ZERO;
    a_d.kick    = kick;
    a_d.pop_hit = ring_nonempty;
    if (!in_action) begin
      if (wa == dtkc_pkg::WA_DEPTH) begin
        a_d.sel = RS_IMM;
        a_d.imm = dtkc_pkg::DATA_W'(ring_depth);
      end else if (wa == dtkc_pkg::WA_POP) begin
        a_d.sel = RS_POP;
      end else if (wa >= dtkc_pkg::WA_CRD_LO && wa <= dtkc_pkg::WA_CRD_HI) begin
        a_d.sel = RS_IMM;
        a_d.imm = dtkc_pkg::CREDIT_FREE;
      end else begin
        a_d.sel = RS_STORE;
        a_d.imm = dtkc_pkg::default_word(wa, chip_q);
      end
    end
  end

  // Input stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vq <= 1'b0;
    end else if (acc) begin
      a_vq <= 1'b1;
    end else if (a_adv) begin
      a_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      a_q <= a_d;
    end
  end

  // Read data selection from the registered memory reads.
  always_comb begin
    case (a_q.sel)
      RS_IMM:   rd_out = a_q.imm;
      RS_POP:   rd_out = a_q.pop_hit ? ring_rdata : '0;
      RS_STORE: rd_out = st_written ? st_rdata : a_q.imm;
      default:  rd_out = '0;
    endcase
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_vq <= 1'b0;
    end else if (a_adv) begin
      m_vq <= 1'b1;
    end else if (m_axis_tready) begin
      m_vq <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_adv) begin
      m_data_q <= {7'b0, a_q.kick.status, a_q.kick.copy_bytes, a_q.kick.copy_dst,
                   a_q.kick.copy_src, a_q.kick.copy_valid, a_q.kick.pulse, rd_out};
    end
  end

  assign m_axis_tvalid = m_vq;
  assign m_axis_tdata  = m_data_q;

  // A full output register with a held input stage must stall the input side.
  a_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (a_vq && m_vq && !m_axis_tready) |-> !s_axis_tready)
    else $error("input accepted while both stages are held");

  // A copy command always has a length and comes with an ok or ring full status.
  a_copy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_vq && m_data_q[33]) |->
      (m_data_q[141:116] != '0) &&
      (m_data_q[144:142] == dtkc_pkg::KS_OK || m_data_q[144:142] == dtkc_pkg::KS_FULL))
    else $error("copy command without length or with wrong status");

  // A done pulse only follows a kick whose id entered the ring.
  a_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_vq && m_data_q[32]) |->
      (m_data_q[144:142] == dtkc_pkg::KS_OK || m_data_q[144:142] == dtkc_pkg::KS_ZERO ||
       m_data_q[144:142] == dtkc_pkg::KS_UNIMPL))
    else $error("done pulse without a ring push");

  // A push grows the ring by exactly one entry.
  a_push : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && kick.push) |=> (ring_depth == 8'($past(ring_depth) + 8'd1)))
    else $error("ring depth did not follow a push");

endmodule
